[rtl/mcw_pkg.sv]
// shared constants and types for the minimum covering window block
`default_nettype none
package mcw_pkg;
  localparam int MAX_TEXT   = 4096;
  localparam int ALPHABET   = 59;
  localparam int ADDR_W     = $clog2(MAX_TEXT);
  localparam int POS_W      = ADDR_W + 1;
  localparam int SLOT_W     = $clog2(ALPHABET + 1);
  localparam int CNT_W      = 13;
  localparam int OUT_W      = 12;
  localparam int SYM_W      = 7;
  localparam int SYM_BASE   = 64;
  localparam int NEED_LIMIT = 8191;
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = $clog2(QDEPTH);

  localparam logic [SLOT_W-1:0] SLOT_NONE = SLOT_W'(ALPHABET);

  typedef enum logic {ACT_PATTERN = 1'b0, ACT_TEXT = 1'b1} action_t;

  typedef struct packed {
    action_t             action;
    logic [SLOT_W-1:0]   slot;
    logic                last;
  } item_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_PAT, ST_TXT, ST_HRD, ST_HSYM, ST_HCHK, ST_BEST, ST_DONE
  } state_t;
endpackage
`default_nettype wire

[rtl/mcw_front.sv]
// front end: accepts words, maps symbols to table slots and queues them
`default_nettype none
module mcw_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          in_action,
  input  wire logic [mcw_pkg::SYM_W-1:0]     in_symbol,
  input  wire logic                          in_last_text,
  output logic                               item_valid,
  output mcw_pkg::item_t                     item,
  input  wire logic                          item_pop
);
  mcw_pkg::item_t                  q_r [mcw_pkg::QDEPTH];
  logic [mcw_pkg::QPTR_W-1:0]      wr_r, wr_nxt, rd_r, rd_nxt;
  logic [mcw_pkg::QPTR_W:0]        cnt_r, cnt_nxt;
  mcw_pkg::item_t                  cls;
  logic                            push;

  always_comb begin
    cls.action = mcw_pkg::action_t'(in_action);
    cls.last   = in_last_text;
    if ((in_symbol >= mcw_pkg::SYM_W'(mcw_pkg::SYM_BASE)) &&
        (in_symbol < mcw_pkg::SYM_W'(mcw_pkg::SYM_BASE + mcw_pkg::ALPHABET))) begin
      cls.slot = mcw_pkg::SLOT_W'(in_symbol - mcw_pkg::SYM_W'(mcw_pkg::SYM_BASE));
    end else begin
      cls.slot = mcw_pkg::SLOT_NONE;
    end
  end

  assign in_stall   = (cnt_r == (mcw_pkg::QPTR_W+1)'(mcw_pkg::QDEPTH));
  assign push       = in_valid && !in_stall;
  assign item_valid = (cnt_r != '0);
  assign item       = q_r[rd_r];

  always_comb begin
    wr_nxt  = push ? wr_r + 1'b1 : wr_r;
    rd_nxt  = (item_pop && item_valid) ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r + (mcw_pkg::QPTR_W+1)'(push)
              - (mcw_pkg::QPTR_W+1)'(item_pop && item_valid);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_r] <= cls;
    end
  end
endmodule
`default_nettype wire

[rtl/mcw_back.sv]
// back end: count tables, text store and the sliding window sequencer
`default_nettype none
module mcw_back (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          item_valid,
  input  wire mcw_pkg::item_t                item,
  output logic                               item_pop,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_found,
  output logic [mcw_pkg::OUT_W-1:0]          out_head,
  output logic [mcw_pkg::OUT_W-1:0]          out_tail,
  output logic                               out_overflow
);
  localparam int CW = mcw_pkg::CNT_W;
  localparam int PW = mcw_pkg::POS_W;
  localparam int AW = mcw_pkg::ADDR_W;
  localparam int SW = mcw_pkg::SLOT_W;

  logic [2*CW-1:0]        tab_mem [mcw_pkg::ALPHABET];
  logic [SW-1:0]          txt_mem [mcw_pkg::MAX_TEXT];
  logic [mcw_pkg::ALPHABET-1:0] tv_r, tv_nxt;

  logic [2*CW-1:0]        tab_q;
  logic                   tab_vq;
  logic [SW-1:0]          txt_q;
  logic                   tab_re, tab_we, txt_re, txt_we;
  logic [SW-1:0]          tab_raddr, tab_waddr;
  logic [2*CW-1:0]        tab_wdata;
  logic [AW-1:0]          txt_raddr, txt_waddr;
  logic [SW-1:0]          txt_wdata;

  mcw_pkg::state_t        state_r, state_nxt;
  mcw_pkg::item_t         cur_r, cur_nxt;
  logic [SW-1:0]          hs_r, hs_nxt;
  logic [5:0]             dist_r, dist_nxt, sat_r, sat_nxt;
  logic [PW-1:0]          wp_r, wp_nxt, head_r, head_nxt;
  logic [AW-1:0]          p_r, p_nxt;
  logic [AW-1:0]          bh_r, bh_nxt, bt_r, bt_nxt;
  logic                   bv_r, bv_nxt, ovf_r, ovf_nxt;
  logic                   ov_r, ov_nxt;
  logic                   of_r, of_nxt, oo_r, oo_nxt;
  logic [mcw_pkg::OUT_W-1:0] oh_r, oh_nxt, ot_r, ot_nxt;

  logic [CW-1:0]          need, win;
  logic                   was_met, in_win;

  assign need    = tab_vq ? tab_q[2*CW-1:CW] : '0;
  assign win     = tab_vq ? tab_q[CW-1:0] : '0;
  assign was_met = (need != '0) && (win >= need);
  assign in_win  = (head_r <= {1'b0, p_r});

  always_comb begin
    state_nxt = state_r;
    cur_nxt   = cur_r;
    hs_nxt    = hs_r;
    dist_nxt  = dist_r;
    sat_nxt   = sat_r;
    wp_nxt    = wp_r;
    head_nxt  = head_r;
    p_nxt     = p_r;
    bh_nxt    = bh_r;
    bt_nxt    = bt_r;
    bv_nxt    = bv_r;
    ovf_nxt   = ovf_r;
    tv_nxt    = tv_r;
    ov_nxt    = ov_r && out_stall;
    of_nxt    = of_r;
    oo_nxt    = oo_r;
    oh_nxt    = oh_r;
    ot_nxt    = ot_r;
    item_pop  = 1'b0;
    tab_re    = 1'b0;
    tab_we    = 1'b0;
    txt_re    = 1'b0;
    txt_we    = 1'b0;
    tab_raddr = cur_r.slot;
    tab_waddr = cur_r.slot;
    tab_wdata = {need, win};
    txt_raddr = head_r[AW-1:0];
    txt_waddr = wp_r[AW-1:0];
    txt_wdata = item.slot;
    case (state_r)
      mcw_pkg::ST_IDLE: begin
        if (item_valid) begin
          item_pop  = 1'b1;
          cur_nxt   = item;
          tab_raddr = item.slot;
          if (item.action == mcw_pkg::ACT_PATTERN) begin
            if (item.slot != mcw_pkg::SLOT_NONE) begin
              tab_re    = 1'b1;
              state_nxt = mcw_pkg::ST_PAT;
            end
          end else if (wp_r < PW'(mcw_pkg::MAX_TEXT)) begin
            txt_we = 1'b1;
            p_nxt  = wp_r[AW-1:0];
            wp_nxt = wp_r + 1'b1;
            if (item.slot != mcw_pkg::SLOT_NONE) begin
              tab_re    = 1'b1;
              state_nxt = mcw_pkg::ST_TXT;
            end else begin
              state_nxt = mcw_pkg::ST_HRD;
            end
          end else begin
            ovf_nxt   = 1'b1;
            state_nxt = mcw_pkg::ST_DONE;
          end
        end
      end
      mcw_pkg::ST_PAT: begin
        if (need < CW'(mcw_pkg::NEED_LIMIT)) begin
          tab_we = 1'b1;
          tab_wdata = {need + 1'b1, win};
          tv_nxt[cur_r.slot] = 1'b1;
          if (need == '0) begin
            dist_nxt = dist_r + 1'b1;
          end
          if (was_met && !(win >= need + 1'b1) && (sat_r != '0)) begin
            sat_nxt = sat_r - 1'b1;
          end
        end
        state_nxt = mcw_pkg::ST_IDLE;
      end
      mcw_pkg::ST_TXT: begin
        tab_we = 1'b1;
        tab_wdata = {need, win + 1'b1};
        tv_nxt[cur_r.slot] = 1'b1;
        if (!was_met && (need != '0) && (win + 1'b1 >= need)) begin
          sat_nxt = sat_r + 1'b1;
        end
        state_nxt = mcw_pkg::ST_HRD;
      end
      mcw_pkg::ST_HRD: begin
        if (in_win) begin
          txt_re    = 1'b1;
          state_nxt = mcw_pkg::ST_HSYM;
        end else begin
          state_nxt = mcw_pkg::ST_BEST;
        end
      end
      mcw_pkg::ST_HSYM: begin
        if (txt_q < SW'(mcw_pkg::ALPHABET)) begin
          tab_re    = 1'b1;
          tab_raddr = txt_q;
          hs_nxt    = txt_q;
          state_nxt = mcw_pkg::ST_HCHK;
        end else begin
          head_nxt  = head_r + 1'b1;
          state_nxt = mcw_pkg::ST_HRD;
        end
      end
      mcw_pkg::ST_HCHK: begin
        if (win <= need) begin
          state_nxt = mcw_pkg::ST_BEST;
        end else begin
          tab_we    = 1'b1;
          tab_waddr = hs_r;
          tab_wdata = {need, win - 1'b1};
          head_nxt  = head_r + 1'b1;
          state_nxt = mcw_pkg::ST_HRD;
        end
      end
      mcw_pkg::ST_BEST: begin
        if ((dist_r != '0) && (sat_r == dist_r) && in_win) begin
          if (!bv_r || ((p_r - head_r[AW-1:0]) < (bt_r - bh_r))) begin
            bh_nxt = head_r[AW-1:0];
            bt_nxt = p_r;
            bv_nxt = 1'b1;
          end
        end
        state_nxt = mcw_pkg::ST_DONE;
      end
      mcw_pkg::ST_DONE: begin
        if (!cur_r.last) begin
          state_nxt = mcw_pkg::ST_IDLE;
        end else if (!ov_r || !out_stall) begin
          ov_nxt    = 1'b1;
          of_nxt    = bv_r;
          oh_nxt    = bv_r ? mcw_pkg::OUT_W'(bh_r) : '0;
          ot_nxt    = bv_r ? mcw_pkg::OUT_W'(bt_r) : '0;
          oo_nxt    = ovf_r;
          tv_nxt    = '0;
          dist_nxt  = '0;
          sat_nxt   = '0;
          wp_nxt    = '0;
          head_nxt  = '0;
          bh_nxt    = '0;
          bt_nxt    = '0;
          bv_nxt    = 1'b0;
          ovf_nxt   = 1'b0;
          state_nxt = mcw_pkg::ST_IDLE;
        end
      end
      default: state_nxt = mcw_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mcw_pkg::ST_IDLE;
      tv_r    <= '0;
      dist_r  <= '0;
      sat_r   <= '0;
      wp_r    <= '0;
      head_r  <= '0;
      bh_r    <= '0;
      bt_r    <= '0;
      bv_r    <= 1'b0;
      ovf_r   <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      tv_r    <= tv_nxt;
      dist_r  <= dist_nxt;
      sat_r   <= sat_nxt;
      wp_r    <= wp_nxt;
      head_r  <= head_nxt;
      bh_r    <= bh_nxt;
      bt_r    <= bt_nxt;
      bv_r    <= bv_nxt;
      ovf_r   <= ovf_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    hs_r  <= hs_nxt;
    p_r   <= p_nxt;
    of_r  <= of_nxt;
    oo_r  <= oo_nxt;
    oh_r  <= oh_nxt;
    ot_r  <= ot_nxt;
  end

  always_ff @(posedge clk) begin
    if (tab_we) begin
      tab_mem[tab_waddr] <= tab_wdata;
    end
    if (tab_re) begin
      tab_q  <= tab_mem[tab_raddr];
      tab_vq <= tv_r[tab_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (txt_we) begin
      txt_mem[txt_waddr] <= txt_wdata;
    end
    if (txt_re) begin
      txt_q <= txt_mem[txt_raddr];
    end
  end

  assign out_valid    = ov_r;
  assign out_found    = of_r;
  assign out_head     = oh_r;
  assign out_tail     = ot_r;
  assign out_overflow = oo_r;

  a_sat_le_dist: assert property (@(posedge clk) disable iff (!rst_n)
    sat_r <= dist_r) else $error("satisfied tally above distinct count");
  a_head_le_wp: assert property (@(posedge clk) disable iff (!rst_n)
    head_r <= wp_r) else $error("window head past write position");
  a_hchk_slot: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == mcw_pkg::ST_HCHK |-> hs_r < SW'(mcw_pkg::ALPHABET))
    else $error("head check on symbol without table entry");
  a_best_done: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == mcw_pkg::ST_BEST |=> state_r == mcw_pkg::ST_DONE)
    else $error("best update not followed by completion");
endmodule
`default_nettype wire

[rtl/minimum_covering_window_top.sv]
// top level of the minimum covering window block
// Pattern words build per-symbol need counts; text words slide a window over a 4096-entry
// text store and keep the earliest shortest covering window. In the back end a pattern word
// reads its count table entry and writes the need count back plus one. A text word is stored,
// its window count is raised, and the head loop reads the text store and the count table one
// after the other, popping the head symbol while its window count exceeds its need count.
// Symbols outside the table skip the table steps. The back end takes no new word before it is
// done with the last. A text word past the store sets the overflow flag and is not stored.
// A four-word queue sits between the front end and the back end. The result goes out on the
// text word marked last_text and waits in an output register; while an earlier result still waits
// there, the back end holds the last word. The count table is then cleared at once through
// per-entry valid bits, so no clearing pass is needed.
`default_nettype none
module minimum_covering_window_top (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          in_action,
  input  wire logic [mcw_pkg::SYM_W-1:0]     in_symbol,
  input  wire logic                          in_last_text,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_found,
  output logic [mcw_pkg::OUT_W-1:0]          out_head,
  output logic [mcw_pkg::OUT_W-1:0]          out_tail,
  output logic                               out_overflow
);
  logic            item_valid, item_pop;
  mcw_pkg::item_t  item;

  mcw_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_action, .in_symbol, .in_last_text,
    .item_valid, .item, .item_pop
  );

  mcw_back u_back (
    .clk, .rst_n, .item_valid, .item, .item_pop,
    .out_valid, .out_stall, .out_found, .out_head, .out_tail, .out_overflow
  );
endmodule
`default_nettype wire

[tb/tb_minimum_covering_window_top.sv]
// testbench for the minimum covering window block: directed and random jobs against a predictor
`timescale 1ns / 1ps
`default_nettype none
module tb_minimum_covering_window_top;

  localparam int WATCHDOG_LIMIT = 60000;

  typedef struct packed {
    mcw_pkg::action_t action;
    logic [6:0] symbol;
    logic       last;
  } word_t;

  typedef struct packed {
    logic        found;
    logic [11:0] head;
    logic [11:0] tail;
    logic        overflow;
  } window_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic in_action;
  logic [mcw_pkg::SYM_W-1:0] in_symbol;
  logic in_last_text;
  logic out_valid;
  logic out_stall;
  logic out_found;
  logic [mcw_pkg::OUT_W-1:0] out_head;
  logic [mcw_pkg::OUT_W-1:0] out_tail;
  logic out_overflow;

  word_t   pending_words[$];
  window_t expected_windows[$];
  int      error_count;
  int      cycle_count;
  int      quiet_cycles;
  int      hold_left;
  bit      pressure_done;

  // predictor state
  int  need_cnt[mcw_pkg::ALPHABET];
  int  win_cnt[mcw_pkg::ALPHABET];
  int  distinct;
  int  satisfied;
  logic [6:0] text_mem[mcw_pkg::MAX_TEXT];
  int  wpos;
  int  whead;
  int  best_h;
  int  best_t;
  bit  best_ok;
  bit  ovf;

  minimum_covering_window_top i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_action(in_action),
    .in_symbol(in_symbol), .in_last_text(in_last_text),
    .out_valid(out_valid), .out_stall(out_stall), .out_found(out_found),
    .out_head(out_head), .out_tail(out_tail), .out_overflow(out_overflow)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int slot_of(logic [6:0] code);
    if (code < mcw_pkg::SYM_BASE || code - mcw_pkg::SYM_BASE >= mcw_pkg::ALPHABET)
      return mcw_pkg::ALPHABET;
    return code - mcw_pkg::SYM_BASE;
  endfunction

  function automatic bit met(int k);
    return need_cnt[k] > 0 && win_cnt[k] >= need_cnt[k];
  endfunction

  function automatic void clear_job();
    foreach (need_cnt[i]) begin
      need_cnt[i] = 0;
      win_cnt[i] = 0;
    end
    distinct = 0;
    satisfied = 0;
    wpos = 0;
    whead = 0;
    best_h = 0;
    best_t = 0;
    best_ok = 0;
    ovf = 0;
  endfunction

  function automatic void predict_window(word_t w);
    int k;
    int h;
    int p;
    bit was;
    window_t r;
    k = slot_of(w.symbol);
    if (w.action == mcw_pkg::ACT_PATTERN) begin
      if (k < mcw_pkg::ALPHABET && need_cnt[k] < mcw_pkg::NEED_LIMIT) begin
        was = met(k);
        if (need_cnt[k] == 0) distinct++;
        need_cnt[k]++;
        if (was && !met(k) && satisfied > 0) satisfied--;
      end
      return;
    end
    if (wpos < mcw_pkg::MAX_TEXT) begin
      p = wpos;
      text_mem[p] = w.symbol;
      wpos = p + 1;
      if (k < mcw_pkg::ALPHABET) begin
        was = met(k);
        win_cnt[k]++;
        if (!was && met(k)) satisfied++;
      end
      while (whead <= p) begin
        h = slot_of(text_mem[whead]);
        if (h < mcw_pkg::ALPHABET) begin
          if (win_cnt[h] <= need_cnt[h]) break;
          win_cnt[h]--;
        end
        whead++;
      end
      if (distinct > 0 && satisfied == distinct && whead <= p) begin
        if (!best_ok || p - whead < best_t - best_h) begin
          best_h = whead;
          best_t = p;
          best_ok = 1;
        end
      end
    end else begin
      ovf = 1;
    end
    if (!w.last) return;
    r.found = best_ok;
    r.head = best_ok ? best_h[11:0] : '0;
    r.tail = best_ok ? best_t[11:0] : '0;
    r.overflow = ovf;
    expected_windows.push_back(r);
    clear_job();
  endfunction

  task automatic add_word(mcw_pkg::action_t a, logic [6:0] s, logic l);
    word_t w;
    w.action = a;
    w.symbol = s;
    w.last = l;
    pending_words.push_back(w);
  endtask

  function automatic logic [6:0] pick_symbol();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return 7'(65 + $urandom_range(0, 3));
    if (r < 92) return 7'($urandom_range(64, 122));
    return 7'($urandom_range(0, 127));
  endfunction

  // driver: offers words and feeds each accepted one to the predictor
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_action <= 1'b0;
      in_symbol <= '0;
      in_last_text <= 1'b0;
    end else begin
      if (in_valid && !in_stall) predict_window(word_t'({in_action, in_symbol, in_last_text}));
      if (!in_valid || !in_stall) begin
        if (pending_words.size() > 0 &&
            ((cycle_count > 3000 && cycle_count < 9000) || $urandom_range(0, 99) >= 33)) begin
          word_t w;
          w = pending_words.pop_front();
          in_valid <= 1'b1;
          in_action <= w.action;
          in_symbol <= w.symbol;
          in_last_text <= w.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: random stall, one long hold-off, checks each result word
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
      pressure_done <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_windows.size() == 0) begin
          $error("unexpected result word");
          error_count++;
        end else begin
          window_t e;
          e = expected_windows.pop_front();
          if (out_found !== e.found) begin
            $error("found: expected %0d actual %0d", e.found, out_found);
            error_count++;
          end
          if (out_head !== e.head) begin
            $error("head: expected %0d actual %0d", e.head, out_head);
            error_count++;
          end
          if (out_tail !== e.tail) begin
            $error("tail: expected %0d actual %0d", e.tail, out_tail);
            error_count++;
          end
          if (out_overflow !== e.overflow) begin
            $error("overflow: expected %0d actual %0d", e.overflow, out_overflow);
            error_count++;
          end
        end
      end
      if (!pressure_done && cycle_count == 1500) begin
        hold_left <= 400;
        pressure_done <= 1'b1;
        out_stall <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else if (cycle_count > 3000 && cycle_count < 9000) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < 33);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || hold_left > 0) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("minimum_covering_window_top verification failed");
        $finish;
      end
    end
  end

  initial begin
    int plen;
    int tlen;
    rst_n = 1'b0;
    error_count = 0;
    cycle_count = 0;
    quiet_cycles = 0;
    clear_job();

    // directed: basic job
    add_word(mcw_pkg::ACT_PATTERN, 7'd65, 1'b0);
    add_word(mcw_pkg::ACT_PATTERN, 7'd66, 1'b0);
    add_word(mcw_pkg::ACT_PATTERN, 7'd65, 1'b0);
    add_word(mcw_pkg::ACT_TEXT, 7'd65, 1'b0);
    add_word(mcw_pkg::ACT_TEXT, 7'd67, 1'b0);
    add_word(mcw_pkg::ACT_TEXT, 7'd66, 1'b0);
    add_word(mcw_pkg::ACT_TEXT, 7'd65, 1'b1);
    // empty pattern, odd codes, last on pattern is ignored
    add_word(mcw_pkg::ACT_PATTERN, 7'd0, 1'b1);
    add_word(mcw_pkg::ACT_PATTERN, 7'd127, 1'b0);
    add_word(mcw_pkg::ACT_PATTERN, 7'd123, 1'b0);
    add_word(mcw_pkg::ACT_TEXT, 7'd0, 1'b0);
    add_word(mcw_pkg::ACT_TEXT, 7'd127, 1'b1);
    // table extremes, pattern symbol after text has begun
    add_word(mcw_pkg::ACT_PATTERN, 7'd64, 1'b0);
    add_word(mcw_pkg::ACT_PATTERN, 7'd122, 1'b0);
    add_word(mcw_pkg::ACT_TEXT, 7'd122, 1'b0);
    add_word(mcw_pkg::ACT_TEXT, 7'd64, 1'b0);
    add_word(mcw_pkg::ACT_PATTERN, 7'd64, 1'b0);
    add_word(mcw_pkg::ACT_TEXT, 7'd63, 1'b0);
    add_word(mcw_pkg::ACT_TEXT, 7'd64, 1'b0);
    add_word(mcw_pkg::ACT_TEXT, 7'd122, 1'b1);

    // random jobs
    for (int n = 0; n < 930; ) begin
      plen = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 6);
      tlen = $urandom_range(1, 40);
      for (int i = 0; i < plen; i++) begin
        add_word(mcw_pkg::ACT_PATTERN, pick_symbol(), $urandom_range(0, 9) == 0);
        n++;
      end
      for (int i = 0; i < tlen; i++) begin
        if ($urandom_range(0, 29) == 0) begin
          add_word(mcw_pkg::ACT_PATTERN, pick_symbol(), 1'b0);
          n++;
        end
        add_word(mcw_pkg::ACT_TEXT, pick_symbol(), i == tlen - 1);
        n++;
      end
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_words.size() == 0);
    @(posedge clk);
    while (in_valid || expected_windows.size() > 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (error_count == 0 && expected_windows.size() == 0) begin
      $display("minimum_covering_window_top verification clean");
    end else begin
      $display("minimum_covering_window_top verification failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
